FILE: hdl/domain_transform_recursive_row_filter_defines.svh
// Assertion macros shared by the row filter modules.
`ifndef DOMAIN_TRANSFORM_RECURSIVE_ROW_FILTER_DEFINES_SVH
`define DOMAIN_TRANSFORM_RECURSIVE_ROW_FILTER_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define DTRF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true outside reset.
`define DTRF_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hdl/dtrf_pkg.sv
package dtrf_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int WEIGHT_BITS   = 16;
  localparam int CHANNELS      = 3;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int DIST_BITS     = SAMPLE_BITS + 2;

  localparam logic [1:0] REG_DECAY    = 2'd0;
  localparam logic [1:0] REG_RATIO    = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic                                   op;
    logic                                   first;
    logic [CHANNELS-1:0]                    mask;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   data;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   guide;
  } q_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIST_BITS-1:0] l1_sum;
  } wgt_req_t;

  typedef struct packed {
    logic                   ready;
    logic                   done;
    logic [WEIGHT_BITS-1:0] weight;
  } wgt_rsp_t;

endpackage

FILE: hdl/dtrf_front.sv
`include "domain_transform_recursive_row_filter_defines.svh"

module dtrf_front import dtrf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,  // data_ch0, data_ch1, data_ch2, guide_ch0, guide_ch1, guide_ch2
  input  logic [1:0]    s_axis_tuser,  // opcode, first_in_row
  input  logic [1:0]    chan_used_i,
  output logic          q_valid_o,
  output q_item_t       q_item_o,
  input  logic          q_pop_i
);

  logic [1:0]          cnt_q;
  logic                head_q;
  logic                tail_q;
  q_item_t             slot_q [2];
  q_item_t             item;
  logic [CHANNELS-1:0] mask;
  logic [1:0]          nact;
  logic                take;

  always_comb begin
    nact = (chan_used_i == 2'd0) ? 2'd1 : chan_used_i;
    if (nact > 2'(CHANNELS)) begin
      nact = 2'(CHANNELS);
    end
    for (int c = 0; c < CHANNELS; c++) begin
      mask[c] = (c < int'(nact));
    end
  end

  always_comb begin
    item.op    = s_axis_tuser[0];
    item.first = s_axis_tuser[1];
    item.mask  = mask;
    for (int c = 0; c < CHANNELS; c++) begin
      item.data[c]  = mask[c] ? s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
      item.guide[c] = mask[c] ?
          s_axis_tdata[(CHANNELS+c)*SAMPLE_BITS +: SAMPLE_BITS] : '0;
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_item_o      = slot_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
      tail_q <= 1'b0;
    end else begin
      if (take) begin
        tail_q <= ~tail_q;
      end
      if (q_pop_i) begin
        head_q <= ~head_q;
      end
      cnt_q <= cnt_q + 2'(take) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q[tail_q] <= item;
    end
  end

  `DTRF_NEVER(a_queue_over, cnt_q > 2'd2, "request queue overfilled")
  `DTRF_NEVER(a_queue_under, q_pop_i && (cnt_q == 2'd0), "pop from an empty request queue")

endmodule

FILE: hdl/dtrf_weight.sv
module dtrf_weight import dtrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] decay_i,
  input  logic [15:0] ratio_i,
  input  wgt_req_t    req_i,
  output wgt_rsp_t    rsp_o
);

  localparam logic [3:0] W_BOOT = 4'd0;
  localparam logic [3:0] W_IDLE = 4'd1;
  localparam logic [3:0] W_MUL1 = 4'd2;
  localparam logic [3:0] W_ADD  = 4'd3;
  localparam logic [3:0] W_MUL2 = 4'd4;
  localparam logic [3:0] W_CHK  = 4'd5;
  localparam logic [3:0] W_TM   = 4'd6;
  localparam logic [3:0] W_TR   = 4'd7;
  localparam logic [3:0] W_TC   = 4'd8;
  localparam logic [3:0] W_EXP  = 4'd9;
  localparam logic [3:0] W_RND  = 4'd10;
  localparam logic [3:0] W_OUT  = 4'd11;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] X_LIMIT = 31'(12 << 16);

  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd1:    r = 32'd4294967295;
      4'd2:    r = 32'd2147483647;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741823;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870911;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      4'd13:   r = 32'd330382099;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  logic [3:0]           state_q;
  logic                 boot_q;
  logic [DIST_BITS-1:0] d_q;
  logic [33:0]          p1_q;
  logic [34:0]          hz_q;
  logic [30:0]          x_q;
  logic [3:0]           n_q;
  logic [16:0]          f_q;
  logic [30:0]          term_q;
  logic [30:0]          pr_q;
  logic [30:0]          qe_q;
  logic [3:0]           k_q;
  logic signed [31:0]   sum_q;
  logic [30:0]          v_q;
  logic [30:0]          e1_q;
  logic [15:0]          w_q;

  logic [30:0]        qk;
  logic [30:0]        rem;
  logic [30:0]        quo;
  logic signed [31:0] sum_nx;
  logic [30:0]        sum_cl;
  logic [16:0]        rnd;

  always_comb begin
    qk     = 31'(qe_q * 31'(k_q));
    rem    = pr_q - qk;
    quo    = (rem >= 31'(k_q)) ? qe_q + 31'd1 : qe_q;
    sum_nx = k_q[0] ? sum_q - $signed({1'b0, quo}) : sum_q + $signed({1'b0, quo});
    sum_cl = sum_nx[31] ? 31'd0 : sum_nx[30:0];
    rnd    = 17'((v_q + 31'd8192) >> 14);
  end

  assign rsp_o.ready  = (state_q == W_IDLE);
  assign rsp_o.done   = (state_q == W_OUT);
  assign rsp_o.weight = w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_BOOT;
      boot_q  <= 1'b1;
    end else begin
      case (state_q)
        W_BOOT: state_q <= W_TM;
        W_IDLE: if (req_i.start) begin
          state_q <= W_MUL1;
        end
        W_MUL1: state_q <= W_ADD;
        W_ADD:  state_q <= W_MUL2;
        W_MUL2: state_q <= W_CHK;
        W_CHK:  state_q <= (x_q >= X_LIMIT) ? W_OUT : W_TM;
        W_TM:   state_q <= W_TR;
        W_TR:   state_q <= W_TC;
        W_TC: begin
          if (k_q != 4'd13) begin
            state_q <= W_TM;
          end else if (boot_q) begin
            state_q <= W_IDLE;
            boot_q  <= 1'b0;
          end else begin
            state_q <= W_EXP;
          end
        end
        W_EXP:   if (n_q == 4'd0) begin
          state_q <= W_RND;
        end
        W_RND:   state_q <= W_OUT;
        W_OUT:   state_q <= W_IDLE;
        default: state_q <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      W_BOOT: begin
        f_q    <= 17'h10000;
        term_q <= ONE_Q30;
        sum_q  <= $signed({1'b0, ONE_Q30});
        k_q    <= 4'd1;
      end
      W_IDLE: d_q <= req_i.l1_sum;
      W_MUL1: p1_q <= 34'(ratio_i) * 34'(d_q);
      W_ADD:  hz_q <= 35'(p1_q) + 35'(1 << 24);
      W_MUL2: x_q <= 31'((51'(decay_i) * 51'(hz_q)) >> 20);
      W_CHK: begin
        w_q    <= '0;
        n_q    <= x_q[19:16];
        f_q    <= {1'b0, x_q[15:0]};
        term_q <= ONE_Q30;
        sum_q  <= $signed({1'b0, ONE_Q30});
        k_q    <= 4'd1;
      end
      W_TM: pr_q <= 31'((48'(term_q) * 48'(f_q)) >> 16);
      W_TR: qe_q <= 31'((63'(pr_q) * 63'(recip(k_q))) >> 32);
      W_TC: begin
        term_q <= quo;
        sum_q  <= sum_nx;
        k_q    <= k_q + 4'd1;
        if (k_q == 4'd13) begin
          if (boot_q) begin
            e1_q <= sum_cl;
          end else begin
            v_q <= sum_cl;
          end
        end
      end
      W_EXP: if (n_q != 4'd0) begin
        v_q <= 31'(((62'(v_q) * 62'(e1_q)) + 62'(1 << 29)) >> 30);
        n_q <= n_q - 4'd1;
      end
      W_RND: w_q <= (rnd > 17'd65535) ? 16'hFFFF : rnd[15:0];
      default: ;
    endcase
  end

endmodule

FILE: hdl/dtrf_back.sv
`include "domain_transform_recursive_row_filter_defines.svh"

module dtrf_back import dtrf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  q_item_t     q_item_i,
  output logic        q_pop_o,
  output wgt_req_t    wgt_req_o,
  input  wgt_rsp_t    wgt_rsp_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // column, out_ch0, out_ch1, out_ch2
  output logic        m_axis_tlast   // row_done
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RL = $clog2(MAX_WIDTH + 1);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SB = SAMPLE_BITS;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_PWAIT  = 3'd1;
  localparam logic [2:0] B_PBLEND = 3'd2;
  localparam logic [2:0] B_PWRITE = 3'd3;
  localparam logic [2:0] B_LBLEND = 3'd4;
  localparam logic [2:0] B_EMIT   = 3'd5;

  typedef logic [CHANNELS-1:0][SB-1:0] pix_t;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          ch_q;
  logic [RL-1:0]          row_len_q;
  logic [RL-1:0]          rd_pos_q;
  pix_t                   prev_guide_q;
  pix_t                   prev_causal_q;
  pix_t                   prev_out_q;
  logic [WEIGHT_BITS-1:0] prev_w_q;
  logic                   out_valid_q;
  logic [63:0]            out_data_q;
  logic                   out_last_q;

  pix_t                   x_q;
  pix_t                   g_q;
  logic                   start_q;
  logic [AW-1:0]          col_q;
  logic [AW-1:0]          j_q;
  logic                   last_q;
  logic [CHANNELS-1:0]    mask_q;
  logic [WEIGHT_BITS-1:0] w_q;
  pix_t                   buf_q;
  pix_t                   crd_q;
  logic [WEIGHT_BITS-1:0] wrd_q;

  pix_t                   cmem [MAX_WIDTH];
  logic [WEIGHT_BITS-1:0] wmem [MAX_WIDTH];

  logic                 can_pop;
  logic                 is_push;
  logic                 start;
  logic [RL-1:0]        col;
  logic                 full;
  logic                 has_pull;
  logic [DIST_BITS-1:0] l1_sum;
  logic                 push_go;
  logic                 pull_go;
  logic                 fire;

  logic [SB-1:0]             a;
  logic [SB-1:0]             b;
  logic [WEIGHT_BITS-1:0]    bw;
  logic signed [SB:0]        diff;
  logic signed [SB+WEIGHT_BITS+1:0] prod;
  logic signed [SB+WEIGHT_BITS+1:0] rnd;
  logic signed [SB+1:0]      res;
  logic [SB-1:0]             blended;
  logic [SB-1:0]             fsel;
  logic [SB-1:0]             osel;

  always_comb begin
    can_pop  = (state_q == B_IDLE) && q_valid_i && wgt_rsp_i.ready;
    is_push  = (q_item_i.op == OP_PUSH);
    start    = q_item_i.first || (row_len_q == '0);
    col      = start ? '0 : row_len_q;
    full     = (col >= RL'(MAX_WIDTH));
    has_pull = (rd_pos_q != '0) && (rd_pos_q <= row_len_q);
    l1_sum   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      l1_sum = l1_sum + DIST_BITS'((q_item_i.guide[c] > prev_guide_q[c]) ?
          q_item_i.guide[c] - prev_guide_q[c] : prev_guide_q[c] - q_item_i.guide[c]);
    end
    if (start) begin
      l1_sum = '0;
    end
    push_go = can_pop && is_push && !full;
    pull_go = can_pop && !is_push && has_pull;
    fire    = (state_q == B_EMIT) && (!out_valid_q || m_axis_tready);
  end

  assign q_pop_o          = can_pop;
  assign wgt_req_o.start  = push_go;
  assign wgt_req_o.l1_sum = l1_sum;

  always_comb begin
    a       = (state_q == B_PBLEND) ? x_q[ch_q] : crd_q[ch_q];
    b       = (state_q == B_PBLEND) ? prev_causal_q[ch_q] : prev_out_q[ch_q];
    bw      = (state_q == B_PBLEND) ? w_q : prev_w_q;
    diff    = $signed({1'b0, b}) - $signed({1'b0, a});
    prod    = diff * $signed({1'b0, bw});
    rnd     = (prod + 32768) >>> 16;
    res     = $signed({2'b00, a}) + rnd[SB+1:0];
    blended = res[SB+1] ? '0 : (res[SB] ? '1 : res[SB-1:0]);
    fsel    = start_q ? a : blended;
    osel    = last_q ? a : blended;
    if (!mask_q[ch_q]) begin
      osel = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (push_go) begin
          state_d = B_PWAIT;
        end else if (pull_go) begin
          state_d = B_LBLEND;
        end
      end
      B_PWAIT:  if (wgt_rsp_i.done) begin
        state_d = B_PBLEND;
      end
      B_PBLEND: if (ch_q == CW'(CHANNELS - 1)) begin
        state_d = B_PWRITE;
      end
      B_PWRITE: state_d = B_IDLE;
      B_LBLEND: if (ch_q == CW'(CHANNELS - 1)) begin
        state_d = B_EMIT;
      end
      B_EMIT:   if (fire) begin
        state_d = B_IDLE;
      end
      default:  state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      ch_q          <= '0;
      row_len_q     <= '0;
      rd_pos_q      <= '0;
      prev_guide_q  <= '0;
      prev_causal_q <= '0;
      prev_out_q    <= '0;
      prev_w_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == B_PBLEND) || (state_q == B_LBLEND)) begin
        ch_q <= (ch_q == CW'(CHANNELS - 1)) ? '0 : ch_q + CW'(1);
      end
      if (state_q == B_PWRITE) begin
        prev_causal_q <= buf_q;
        prev_guide_q  <= g_q;
        row_len_q     <= RL'(col_q) + RL'(1);
        rd_pos_q      <= RL'(col_q) + RL'(1);
      end
      if (fire) begin
        prev_out_q  <= buf_q;
        prev_w_q    <= wrd_q;
        rd_pos_q    <= RL'(j_q);
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_go) begin
      x_q     <= q_item_i.data;
      g_q     <= q_item_i.guide;
      start_q <= start;
      col_q   <= AW'(col);
    end
    if (pull_go) begin
      j_q    <= AW'(rd_pos_q - RL'(1));
      last_q <= (rd_pos_q == row_len_q);
      mask_q <= q_item_i.mask;
    end
    if ((state_q == B_PWAIT) && wgt_rsp_i.done) begin
      w_q <= wgt_rsp_i.weight;
    end
    if (state_q == B_PBLEND) begin
      buf_q[ch_q] <= fsel;
    end else if (state_q == B_LBLEND) begin
      buf_q[ch_q] <= osel;
    end
    if (fire) begin
      out_data_q <= 64'({buf_q[2], buf_q[1], buf_q[0], 11'(j_q)});
      out_last_q <= (j_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_PWRITE) begin
      cmem[col_q] <= buf_q;
      wmem[col_q] <= w_q;
    end
    if (pull_go) begin
      crd_q <= cmem[AW'(rd_pos_q - RL'(1))];
      wrd_q <= wmem[AW'(rd_pos_q - RL'(1))];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `DTRF_ASSERT(a_read_in_row, rd_pos_q <= row_len_q, "read position beyond row length")
  `DTRF_ASSERT(a_row_bound, row_len_q <= RL'(MAX_WIDTH), "row length beyond row store")
  `DTRF_ASSERT(a_emit_source, $rose(out_valid_q) |-> $past(state_q == B_EMIT), "result without pull")

endmodule

FILE: hdl/domain_transform_recursive_row_filter.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata 96 bits, tuser 2 bits
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata 64 bits, tlast
// cfg       in         cfg_we_i                      cfg_idx_i, cfg_data_i
//
// A push waits on the iterative exponential unit, which sums thirteen series terms,
// each by a multiply, a reciprocal multiply and an accumulate, then does one multiply
// per whole unit of the exponent. A push whose weight saturates to zero skips the series.
// A pull passes through the shared blend multiplier one channel at a time.
// After reset the exponential unit first derives its constant.
// A two-entry request queue keeps accepting while a result waits downstream, until both entries fill.
module domain_transform_recursive_row_filter import dtrf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // data_ch0, data_ch1, data_ch2, guide_ch0, guide_ch1, guide_ch2
  input  logic [1:0]  s_axis_tuser,  // opcode, first_in_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // column, out_ch0, out_ch1, out_ch2
  output logic        m_axis_tlast,  // row_done
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] decay_q;
  logic [15:0] ratio_q;
  logic [1:0]  chan_q;

  logic     q_valid;
  q_item_t  q_item;
  logic     q_pop;
  wgt_req_t wgt_req;
  wgt_rsp_t wgt_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= 16'd145;
      ratio_q <= 16'd38400;
      chan_q  <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DECAY:    decay_q <= cfg_data_i;
        REG_RATIO:    ratio_q <= cfg_data_i;
        REG_CHANNELS: chan_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  dtrf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .chan_used_i   (chan_q),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  dtrf_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .decay_i (decay_q),
    .ratio_i (ratio_q),
    .req_i   (wgt_req),
    .rsp_o   (wgt_rsp)
  );

  dtrf_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .wgt_req_o     (wgt_req),
    .wgt_rsp_i     (wgt_rsp),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/sv/domain_transform_recursive_row_filter_tb.sv
module domain_transform_recursive_row_filter_tb;
  import dtrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_MAX   = 2048;
  localparam int WDOG_MAX  = 3000;
  localparam int HOLD_LEN  = 500;
  localparam int SETTLE    = 300;

  typedef struct packed {
    logic [10:0]       column;
    logic [2:0][15:0]  pix;
    logic              row_done;
  } pixel_t;

  typedef struct {
    logic             op;
    logic             first;
    logic [2:0][15:0] dat;
    logic [2:0][15:0] gd;
    bit               typed;
    pixel_t           px;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  domain_transform_recursive_row_filter dut (.*);

  // Predictor state.
  logic [15:0] decay_q, ratio_q;
  logic [1:0]  chans_q;
  logic [2:0][15:0] causal_mem [ROW_MAX];
  logic [15:0] weight_mem [ROW_MAX];
  logic [2:0][15:0] last_guide, last_causal, last_out;
  logic [15:0] last_weight;
  int unsigned row_len, rd_pos;

  pixel_t pending_pixels[$];
  int n_errors, n_requests, n_checked, n_settings, idle_cycles;
  bit held_off;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned exp_series(longint unsigned f);
    longint sum;
    longint unsigned term;
    sum = longint'(1) << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * f) >> 16) / k;
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  function automatic logic [15:0] weight_for(longint unsigned d);
    longint unsigned horiz, x, n, v, e1, r;
    horiz = (64'd1 << 24) + longint'(ratio_q) * d;
    x = (longint'(decay_q) * horiz) >> 20;
    if (x >= (64'd12 << 16)) return '0;
    n = x >> 16;
    v = exp_series(x & 64'hFFFF);
    e1 = exp_series(64'd65536);
    for (longint unsigned i = 0; i < n; i++) v = (v * e1 + (64'd1 << 29)) >> 30;
    r = (v + (64'd1 << 13)) >> 14;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [15:0] mix(logic [15:0] a, logic [15:0] b, logic [15:0] w);
    longint unsigned r;
    r = (longint'(a) * (65536 - longint'(w)) + longint'(b) * longint'(w) + 32768) >> 16;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  task automatic filter_step(input logic op, input logic first, input logic [2:0][15:0] dat,
                             input logic [2:0][15:0] gd, output bit emits, output pixel_t px);
    int unsigned nact, col, j;
    bit start, lastp;
    logic [2:0][15:0] x, g;
    longint unsigned d;
    logic [15:0] w, f, o;
    nact = (chans_q == 0) ? 1 : chans_q;
    emits = 1'b0;
    px = '0;
    if (op == OP_PUSH) begin
      start = first || row_len == 0;
      col = start ? 0 : row_len;
      if (col >= ROW_MAX) return;
      d = 0;
      for (int c = 0; c < 3; c++) begin
        x[c] = (c < nact) ? dat[c] : '0;
        g[c] = (c < nact) ? gd[c] : '0;
        if (!start) d += (g[c] > last_guide[c]) ? g[c] - last_guide[c] : last_guide[c] - g[c];
      end
      w = weight_for(d);
      for (int c = 0; c < 3; c++) begin
        f = start ? x[c] : mix(x[c], last_causal[c], w);
        causal_mem[col][c] = f;
        last_causal[c] = f;
        last_guide[c] = g[c];
      end
      weight_mem[col] = w;
      row_len = col + 1;
      rd_pos = row_len;
    end else if (rd_pos != 0 && rd_pos <= row_len) begin
      j = rd_pos - 1;
      lastp = (j + 1 == row_len);
      for (int c = 0; c < 3; c++) begin
        f = causal_mem[j][c];
        o = lastp ? f : mix(f, last_out[c], last_weight);
        if (c >= nact) o = '0;
        last_out[c] = o;
        px.pix[c] = o;
      end
      last_weight = weight_mem[j];
      rd_pos = j;
      px.column = j[10:0];
      px.row_done = (j == 0);
      emits = 1'b1;
    end
  endtask

  task automatic send(input logic op, input logic first, input logic [2:0][15:0] dat,
                      input logic [2:0][15:0] gd, input bit typed, input pixel_t typed_px);
    int gap;
    bit emits;
    pixel_t px;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gd, dat};
    s_axis_tuser  <= {first, op};
    do @(posedge clk_i); while (!s_axis_tready);
    filter_step(op, first, dat, gd, emits, px);
    if (emits) pending_pixels.push_back(typed ? typed_px : px);
    n_requests++;
  endtask

  task automatic send_rand(input logic op, input logic first, input logic [2:0][15:0] gd);
    logic [2:0][15:0] dat;
    dat = {16'($urandom), 16'($urandom), 16'($urandom)};
    send(op, first, dat, gd, 1'b0, '0);
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [15:0] dec, input logic [15:0] rat,
                                input logic [1:0] ch);
    drain_and_idle();
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_DECAY; cfg_data_i <= dec;
    @(posedge clk_i);
    cfg_idx_i <= REG_RATIO; cfg_data_i <= rat;
    @(posedge clk_i);
    cfg_idx_i <= REG_CHANNELS; cfg_data_i <= {14'd0, ch};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    decay_q = dec; ratio_q = rat; chans_q = ch;
    n_settings++;
  endtask

  task automatic random_rows(input int quota);
    int target, len, pulls;
    logic [2:0][15:0] gd;
    target = n_requests + quota;
    gd = {16'($urandom), 16'($urandom), 16'($urandom)};
    while (n_requests < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        for (int c = 0; c < 3; c++)
          if ($urandom_range(0, 4) == 0) gd[c] = 16'($urandom);
          else gd[c] = gd[c] + 16'($urandom_range(0, 600)) - 16'd300;
        send_rand(OP_PUSH, (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
                  gd);
      end
      pulls = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : len + $urandom_range(0, 1);
      for (int i = 0; i < pulls; i++) send_rand(OP_PULL, 1'($urandom), gd);
      if ($urandom_range(0, 7) == 0)
        send_rand(1'($urandom), 1'($urandom), {16'($urandom), 16'($urandom), 16'($urandom)});
    end
  endtask

  // Receiver: random stall per result, with one long hold-off to back up the input side.
  initial begin
    int stall;
    pixel_t want, got;
    m_axis_tready = 1'b0;
    held_off = 1'b0;
    forever begin
      stall = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (!held_off && n_checked == 40) begin
        stall = HOLD_LEN;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got.column = m_axis_tdata[10:0];
      got.pix[0] = m_axis_tdata[26:11];
      got.pix[1] = m_axis_tdata[42:27];
      got.pix[2] = m_axis_tdata[58:43];
      got.row_done = m_axis_tlast;
      n_checked++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel at column %0d", got.column);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.column != want.column) begin
          $error("column: expected %0d, got %0d", want.column, got.column); n_errors++;
        end
        for (int c = 0; c < 3; c++)
          if (got.pix[c] != want.pix[c]) begin
            $error("out_ch%0d: expected %0h, got %0h", c, want.pix[c], got.pix[c]); n_errors++;
          end
        if (got.row_done != want.row_done) begin
          $error("row_done: expected %0b, got %0b", want.row_done, got.row_done); n_errors++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("domain_transform_recursive_row_filter verification failed");
        $finish;
      end
    end
  end

  stim_row_t directed[$];
  logic [15:0] ph_decay[5] = '{16'd0, 16'd65535, 16'd4096, 16'd300, 16'd1448};
  logic [15:0] ph_ratio[5] = '{16'd0, 16'd65535, 16'd256, 16'd1000, 16'd38400};
  logic [1:0]  ph_chans[5] = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd3};

  initial begin
    logic [2:0][15:0] ones, zeros, mid;
    ones = '1; zeros = '0; mid = {16'h8000, 16'h1234, 16'h00FF};
    decay_q = 16'd145; ratio_q = 16'd38400; chans_q = 2'd3;
    last_guide = '0; last_causal = '0; last_out = '0; last_weight = '0;
    row_len = 0; rd_pos = 0;
    n_errors = 0; n_requests = 0; n_checked = 0; n_settings = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    cfg_we_i = 1'b0; cfg_idx_i = REG_DECAY; cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed = '{
      '{OP_PULL, 1'b0, ones,  ones,  1'b0, '0},
      '{OP_PUSH, 1'b0, ones,  zeros, 1'b0, '0},
      '{OP_PULL, 1'b1, zeros, zeros, 1'b1, '{11'd0, ones, 1'b1}},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PUSH, 1'b0, zeros, ones,  1'b0, '0},
      '{OP_PUSH, 1'b0, mid,   zeros, 1'b0, '0},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PUSH, 1'b0, ones,  mid,   1'b0, '0},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PULL, 1'b0, zeros, zeros, 1'b0, '0},
      '{OP_PUSH, 1'b1, mid,   ones,  1'b0, '0},
      '{OP_PUSH, 1'b0, zeros, ones,  1'b0, '0},
      '{OP_PUSH, 1'b1, zeros, zeros, 1'b0, '0},
      '{OP_PULL, 1'b0, ones,  ones,  1'b1, '{11'd0, zeros, 1'b1}},
      '{OP_PULL, 1'b1, ones,  ones,  1'b0, '0}
    };
    foreach (directed[i])
      send(directed[i].op, directed[i].first, directed[i].dat, directed[i].gd,
           directed[i].typed, directed[i].px);

    random_rows(200);
    for (int p = 0; p < 5; p++) begin
      write_settings(ph_decay[p], ph_ratio[p], ph_chans[p]);
      random_rows(190);
    end

    drain_and_idle();
    $display("Sent %0d requests over %0d register settings, with stalls on both sides.",
             n_requests, n_settings + 1);
    $display("Checked %0d filtered pixels with %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && pending_pixels.size() == 0)
      $display("domain_transform_recursive_row_filter verification clean");
    else
      $display("domain_transform_recursive_row_filter verification failed");
    $finish;
  end

endmodule
